>>> rtl/rs2c_pkg.sv
// Package for the radar spherical-to-cartesian converter: types, constants and helpers.
`default_nettype none
package rs2c_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int NUM_STG      = CORDIC_STEPS + 5;
    localparam int STG_MUL_A    = CORDIC_STEPS + 1;
    localparam int STG_RND_B    = CORDIC_STEPS + 2;
    localparam int STG_MUL_C    = CORDIC_STEPS + 3;
    localparam int STG_OUT      = CORDIC_STEPS + 4;

    localparam logic signed [33:0] CORDIC_K  = 34'sd652032874;
    localparam logic signed [19:0] PI_U      = 20'sd205887;
    localparam logic signed [19:0] PI_HALF_U = 20'sd102944;
    localparam logic signed [47:0] POS_MAX   = 48'sd131071;

    typedef struct packed {
        logic [16:0]        depth;
        logic signed [15:0] azimuth;
        logic signed [15:0] altitude;
        logic signed [15:0] speed;
        logic               last;
    } t_pass;

    typedef struct packed {
        logic signed [33:0] x;
        logic signed [33:0] y;
        logic signed [19:0] th;
        logic               neg;
    } t_rot;

    typedef struct packed {
        t_pass p;
        t_rot  a;
        t_rot  e;
    } t_cs;

    function automatic logic signed [19:0] atan_lut(input logic [3:0] idx);
        logic signed [19:0] v;
        case (idx)
            4'd0:    v = 20'sd51472;
            4'd1:    v = 20'sd30386;
            4'd2:    v = 20'sd16055;
            4'd3:    v = 20'sd8150;
            4'd4:    v = 20'sd4091;
            4'd5:    v = 20'sd2047;
            4'd6:    v = 20'sd1024;
            4'd7:    v = 20'sd512;
            4'd8:    v = 20'sd256;
            4'd9:    v = 20'sd128;
            4'd10:   v = 20'sd64;
            4'd11:   v = 20'sd32;
            4'd12:   v = 20'sd16;
            4'd13:   v = 20'sd8;
            4'd14:   v = 20'sd4;
            default: v = 20'sd2;
        endcase
        return v;
    endfunction

    // fold into +-pi/2, start vector at (K, 0)
    function automatic t_rot rot_init(input logic signed [15:0] ang);
        t_rot r;
        logic signed [19:0] th;
        th = {{1{ang[15]}}, ang, 3'b000};
        r.x = CORDIC_K;
        r.y = '0;
        r.neg = 1'b0;
        if (th > PI_HALF_U) begin
            th = th - PI_U;
            r.neg = 1'b1;
        end else if (th < -PI_HALF_U) begin
            th = th + PI_U;
            r.neg = 1'b1;
        end
        r.th = th;
        return r;
    endfunction

    function automatic t_rot rot_step(input t_rot r, input logic [3:0] idx);
        t_rot o;
        o = r;
        if (r.th >= 0) begin
            o.x  = r.x - (r.y >>> idx);
            o.y  = r.y + (r.x >>> idx);
            o.th = r.th - atan_lut(idx);
        end else begin
            o.x  = r.x + (r.y >>> idx);
            o.y  = r.y - (r.x >>> idx);
            o.th = r.th + atan_lut(idx);
        end
        return o;
    endfunction

    function automatic logic signed [17:0] clamp_pos(input logic signed [47:0] v);
        logic signed [47:0] c;
        if (v > POS_MAX) begin
            c = POS_MAX;
        end else if (v < -POS_MAX) begin
            c = -POS_MAX;
        end else begin
            c = v;
        end
        return c[17:0];
    endfunction

endpackage
`default_nettype wire

>>> rtl/radar_spherical_to_cartesian.sv
// Top level: pipelined radar spherical-to-cartesian converter.
// Slave stream takes one detection per transfer: tdata holds depth, azimuth,
// altitude and radial speed, tlast the last-of-frame mark. Master stream gives
// one result per detection: x, y, z, range, speed, azimuth, elevation in
// tdata, the frame mark in tlast.
// Sine and cosine of both angles come from two 16-step CORDIC chains, one
// rotation per register stage, followed by two multiply stages each with a
// rounding stage after it: 21 register stages in all.
// Each item passes 21 register stages from the input transfer to output valid;
// throughput is one item per cycle unless the receiver stalls, set by the
// one-step-per-stage CORDIC and pipelined multipliers.
// Each stage has its own valid bit and advances when the next stage is empty
// or advancing, so bubbles close up and a stalled receiver holds the last
// stage while earlier stages keep filling. The pipeline stops accepting only
// when every stage is full.
// Reset clears all valid bits; no item is lost or repeated across a stall.
`default_nettype none
module radar_spherical_to_cartesian
    import rs2c_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_s_tvalid,
    output logic              o_s_tready,
    // depth[16:0], azimuth[32:17], altitude[48:33], radial_speed[64:49], zero pad
    input  wire logic [71:0]  i_s_tdata,
    input  wire logic         i_s_tlast,
    output logic              o_m_tvalid,
    input  wire logic         i_m_tready,
    // x_pos[17:0], y_pos[35:18], z_pos[53:36], range_out[70:54], speed_out[86:71],
    // azimuth_out[102:87], elevation_out[118:103], zero pad
    output logic [119:0]      o_m_tdata,
    output logic              o_m_tlast
);

    logic [NUM_STG-1:0] r_vld;
    logic [NUM_STG-1:0] en;

    always_comb begin
        en[NUM_STG-1] = ~r_vld[NUM_STG-1] | i_m_tready;
        for (int k = NUM_STG - 2; k >= 0; k--) begin
            en[k] = ~r_vld[k] | en[k+1];
        end
    end

    assign o_s_tready = en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) begin
                r_vld[0] <= i_s_tvalid;
            end
            for (int k = 1; k < NUM_STG; k++) begin
                if (en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // CORDIC stages: index 0 holds the folded angles, index i after step i-1
    t_cs   r_cs [0:CORDIC_STEPS];
    t_pass in_pass;

    assign in_pass.depth    = i_s_tdata[16:0];
    assign in_pass.azimuth  = i_s_tdata[32:17];
    assign in_pass.altitude = i_s_tdata[48:33];
    assign in_pass.speed    = i_s_tdata[64:49];
    assign in_pass.last     = i_s_tlast;

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_cs[0].p <= in_pass;
            r_cs[0].a <= rot_init(in_pass.azimuth);
            r_cs[0].e <= rot_init(in_pass.altitude);
        end
        for (int i = 1; i <= CORDIC_STEPS; i++) begin
            if (en[i]) begin
                r_cs[i].p <= r_cs[i-1].p;
                r_cs[i].a <= rot_step(r_cs[i-1].a, 4'(i - 1));
                r_cs[i].e <= rot_step(r_cs[i-1].e, 4'(i - 1));
            end
        end
    end

    // undo the half-turn fold
    logic signed [33:0] cos_az, sin_az, cos_alt, sin_alt;
    t_cs fin;
    assign fin     = r_cs[CORDIC_STEPS];
    assign cos_az  = fin.a.neg ? -fin.a.x : fin.a.x;
    assign sin_az  = fin.a.neg ? -fin.a.y : fin.a.y;
    assign cos_alt = fin.e.neg ? -fin.e.x : fin.e.x;
    assign sin_alt = fin.e.neg ? -fin.e.y : fin.e.y;

    // first multiply
    t_pass              r_pa;
    logic signed [51:0] r_px, r_py, r_pz;
    logic signed [33:0] r_ca;
    logic signed [17:0] d_s;
    assign d_s = $signed({1'b0, fin.p.depth});

    always_ff @(posedge i_clk) begin
        if (en[STG_MUL_A]) begin
            r_pa <= fin.p;
            r_px <= d_s * cos_az;
            r_py <= d_s * sin_az;
            r_pz <= d_s * sin_alt;
            r_ca <= cos_alt;
        end
    end

    // round to Q.15 products, finish z
    t_pass              r_pb;
    logic signed [35:0] r_tx, r_ty;
    logic signed [17:0] r_zb;
    logic signed [33:0] r_cb;
    logic signed [51:0] rx_b, ry_b, rz_b;
    assign rx_b = (r_px + 52'sd16384) >>> 15;
    assign ry_b = (r_py + 52'sd16384) >>> 15;
    assign rz_b = (r_pz + 52'sd536870912) >>> 30;

    always_ff @(posedge i_clk) begin
        if (en[STG_RND_B]) begin
            r_pb <= r_pa;
            r_tx <= rx_b[35:0];
            r_ty <= ry_b[35:0];
            r_zb <= clamp_pos(rz_b[47:0]);
            r_cb <= r_ca;
        end
    end

    // second multiply
    t_pass              r_pc;
    logic signed [69:0] r_mx, r_my;
    logic signed [17:0] r_zc;

    always_ff @(posedge i_clk) begin
        if (en[STG_MUL_C]) begin
            r_pc <= r_pb;
            r_mx <= r_tx * r_cb;
            r_my <= r_ty * r_cb;
            r_zc <= r_zb;
        end
    end

    // final rounding and saturation, y negated; sign kept through the widening
    logic signed [70:0] rx_d, ry_d;
    assign rx_d = ($signed({r_mx[69], r_mx}) + 71'sd17592186044416) >>> 45;
    assign ry_d = (-$signed({r_my[69], r_my}) + 71'sd17592186044416) >>> 45;

    t_pass              r_pd;
    logic signed [17:0] r_x, r_y, r_z;

    always_ff @(posedge i_clk) begin
        if (en[STG_OUT]) begin
            r_pd <= r_pc;
            r_x  <= clamp_pos(rx_d[47:0]);
            r_y  <= clamp_pos(ry_d[47:0]);
            r_z  <= r_zc;
        end
    end

    assign o_m_tvalid = r_vld[STG_OUT];
    assign o_m_tlast  = r_pd.last;
    assign o_m_tdata  = {1'b0, r_pd.altitude, r_pd.azimuth, r_pd.speed, r_pd.depth,
                         r_z, r_y, r_x};

    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_tvalid |-> o_s_tready)
        else $error("ready low with empty output stage");

    a_accept_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> r_vld[0])
        else $error("accepted transfer not captured");

    a_sat_x: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[17:0] != 18'h20000 && o_m_tdata[35:18] != 18'h20000
                        && o_m_tdata[53:36] != 18'h20000))
        else $error("coordinate beyond saturation bound");

endmodule
`default_nettype wire
